FILE: hdl/base64_stream_decoder_defines.svh
// assertion macros for the base64 stream decoder
// needs clk and rst_n in the scope where a macro is used
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTH
`define B64D_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT_IMPLY(lbl, ante, cons)
`define B64D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/b64d_pkg.sv
// shared types, constants and the character classifier of the base64 decoder
// no dependencies
package b64d_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

    localparam logic [5:0] IDX_PLUS     = 6'd62;
    localparam logic [5:0] IDX_SLASH    = 6'd63;
    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;

    // byte positions within a group
    localparam logic [1:0] BYTE_FIRST  = 2'd0;
    localparam logic [1:0] BYTE_SECOND = 2'd1;
    localparam logic [1:0] BYTE_THIRD  = 2'd2;

    typedef struct packed {
        logic [5:0] idx;
        logic       pad;
        logic       bad;
    } char_class_t;

    // one closed group handed from front to back
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  last_idx;
        logic        eom;
        logic        err;
    } group_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r.idx = 6'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r.idx = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            r.idx = 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
        end
        else if (c == CHAR_PLUS)
        begin
            r.idx = IDX_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            r.idx = IDX_SLASH;
        end
        else if (c == CHAR_EQUALS)
        begin
            r.pad = 1'b1;
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/b64d_front.sv
// front end: classifies characters and gathers them into closed groups
// depends on b64d_pkg
module b64d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              end_of_message,
    output logic              push,
    output b64d_pkg::group_t  grp
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [2:0]  pads_reg, pads_next;
    logic        err_reg, err_next;

    b64d_pkg::char_class_t cls;
    logic        close;
    logic [23:0] word_full;
    logic [2:0]  pads_open;
    logic [2:0]  pads_close;

    always_comb
    begin
        cls        = b64d_pkg::classify(char_code);
        close      = (pos_reg == 2'd3) || end_of_message;
        word_full  = {acc_reg, cls.idx};
        pads_open  = pads_reg + {2'b00, cls.pad};
        // missing positions count as padding
        pads_close = pads_open + {1'b0, ~pos_reg};

        grp.eom = end_of_message;
        grp.err = err_reg | cls.bad;
        case (pos_reg)
            2'd0:    grp.word = {word_full[5:0], 18'd0};
            2'd1:    grp.word = {word_full[11:0], 12'd0};
            2'd2:    grp.word = {word_full[17:0], 6'd0};
            default: grp.word = word_full;
        endcase
        if (pads_close >= 3'd2)
        begin
            grp.last_idx = b64d_pkg::BYTE_FIRST;
        end
        else if (pads_close == 3'd1)
        begin
            grp.last_idx = b64d_pkg::BYTE_SECOND;
        end
        else
        begin
            grp.last_idx = b64d_pkg::BYTE_THIRD;
        end

        push      = accept && close;
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        pads_next = pads_reg;
        err_next  = err_reg;
        if (accept)
        begin
            if (close)
            begin
                acc_next  = '0;
                pos_next  = '0;
                pads_next = '0;
                err_next  = 1'b0;
            end
            else
            begin
                acc_next  = word_full[17:0];
                pos_next  = pos_reg + 2'd1;
                pads_next = pads_open;
                err_next  = grp.err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pos_reg  <= '0;
            pads_reg <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            pads_reg <= pads_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: hdl/b64d_queue.sv
// short group queue between the front and back ends
// depends on b64d_pkg
module b64d_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::group_t  push_grp,
    input  logic              pop,
    output b64d_pkg::group_t  head_grp,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::group_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full     = cnt_reg == CNT_W'(DEPTH);
        empty    = cnt_reg == '0;
        head_grp = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/b64d_back.sv
// back end: splits a closed group into bytes, one beat per cycle unless out_stall holds it
// depends on b64d_pkg
module b64d_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  b64d_pkg::group_t  head_grp,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_byte,
    output logic              group_last,
    output logic              message_last,
    output logic              bad_char
);

    b64d_pkg::group_t grp_reg, grp_next;
    logic [1:0] k_reg, k_next;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_reg, data_next;
    logic       glast_reg, glast_next;
    logic       mlast_reg, mlast_next;
    logic       bad_reg, bad_next;

    logic out_load;
    logic emit;
    logic last;
    logic [7:0] sel_byte;

    always_comb
    begin
        out_load = !out_valid_reg || !out_stall;
        emit     = busy_reg && out_load;
        last     = k_reg == grp_reg.last_idx;
        pop      = !q_empty && (!busy_reg || (emit && last));
        case (k_reg)
            b64d_pkg::BYTE_FIRST:  sel_byte = grp_reg.word[23:16];
            b64d_pkg::BYTE_SECOND: sel_byte = grp_reg.word[15:8];
            default:               sel_byte = grp_reg.word[7:0];
        endcase

        grp_next  = grp_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            grp_next  = head_grp;
            k_next    = b64d_pkg::BYTE_FIRST;
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end

        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        glast_next     = glast_reg;
        mlast_next     = mlast_reg;
        bad_next       = bad_reg;
        if (out_load)
        begin
            out_valid_next = emit;
            data_next      = sel_byte;
            glast_next     = last;
            mlast_next     = last && grp_reg.eom;
            bad_next       = grp_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        data_reg  <= data_next;
        glast_reg <= glast_next;
        mlast_reg <= mlast_next;
        bad_reg   <= bad_next;
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_reg;
    assign group_last   = glast_reg;
    assign message_last = mlast_reg;
    assign bad_char     = bad_reg;

endmodule

FILE: hdl/base64_stream_decoder.sv
// base64 stream decoder top level: front end, group queue, back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the defines header
//
// input channel: one character per beat (char_code, end_of_message) on
// in_valid / in_stall; end_of_message marks the final character
// output channel: one decoded byte per beat with group_last, message_last
// and bad_char on out_valid / out_stall
// throughput: one character per cycle in unless in_stall is high, one byte per
// cycle out unless out_stall is high; the byte splitter in the back end sets the
// output figure, so four characters (three bytes) keep up with a steady
// one-character-per-cycle stream; groups pass queue, group and output registers
// a closed group waits in a QUEUE_DEPTH-entry queue; in_stall rises only
// when that queue is full, so a receiver stall backs up into the queue
// first and the output register holds its beat unchanged meanwhile
// reset: clears the partial group, the queue and the output valid
`include "base64_stream_decoder_defines.svh"
module base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic       group_last,
    output logic       message_last,
    output logic       bad_char
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    b64d_pkg::group_t push_grp;
    b64d_pkg::group_t head_grp;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    b64d_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .push           (push),
        .grp            (push_grp)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64d_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_grp     (head_grp),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .group_last   (group_last),
        .message_last (message_last),
        .bad_char     (bad_char)
    );

    `B64D_ASSERT_IMPLY(a_msg_last_is_group_last, out_valid && message_last, group_last)
    `B64D_ASSERT_IMPLY(a_eom_closes_group, accept && end_of_message, push)
    `B64D_ASSERT_NEXT(a_group_bytes_unbroken, out_valid && !out_stall && !group_last, out_valid)

endmodule
